@@ rtl/lobm_pkg.sv @@
// Shared constants, types and controller state encoding for the order book matcher.
package lobm_pkg;

	localparam int PRICE_LEVELS = 1024;
	localparam int LVL_W = $clog2(PRICE_LEVELS);
	localparam int CUR_W = LVL_W + 1;
	localparam int QTY_W = 16;
	localparam int TICK_W = 10;
	localparam int LEVEL_W = 24;
	localparam int PROFIT_W = 48;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
	localparam logic [PROFIT_W-1:0] PROFIT_MAX = '1;

	// Controller states
	typedef enum logic [3:0] {
		C_CLR,
		C_IDLE,
		C_CHK,
		C_RD,
		C_EV,
		C_AC,
		C_FIN,
		C_RRD,
		C_RWR,
		C_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic ev;
		logic ac;
		logic fin;
		logic rest_rd;
		logic rest_wr;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic walk_more;
		logic rest_needed;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/lobm_ctrl.sv @@
// Controller state machine sequencing the clearing pass, level walk, resting and result hand-off.
module lobm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lobm_pkg::sts_t sts,
	output lobm_pkg::cmd_t cmd
);

	lobm_pkg::state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lobm_pkg::C_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lobm_pkg::C_CLR: begin
				if (sts.clr_done) state_d = lobm_pkg::C_IDLE;
			end
			lobm_pkg::C_IDLE: begin
				if (in_valid) state_d = lobm_pkg::C_CHK;
			end
			lobm_pkg::C_CHK: begin
				state_d = sts.walk_more ? lobm_pkg::C_RD : lobm_pkg::C_FIN;
			end
			lobm_pkg::C_RD:  state_d = lobm_pkg::C_EV;
			lobm_pkg::C_EV:  state_d = lobm_pkg::C_AC;
			lobm_pkg::C_AC:  state_d = lobm_pkg::C_CHK;
			lobm_pkg::C_FIN: begin
				state_d = sts.rest_needed ? lobm_pkg::C_RRD : lobm_pkg::C_OUT;
			end
			lobm_pkg::C_RRD: state_d = lobm_pkg::C_RWR;
			lobm_pkg::C_RWR: state_d = lobm_pkg::C_OUT;
			lobm_pkg::C_OUT: begin
				if (sts.out_free) state_d = lobm_pkg::C_IDLE;
			end
			default: state_d = lobm_pkg::C_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			lobm_pkg::C_CLR: cmd.clr = 1'b1;
			lobm_pkg::C_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lobm_pkg::C_RD:  cmd.rd = 1'b1;
			lobm_pkg::C_EV:  cmd.ev = 1'b1;
			lobm_pkg::C_AC:  cmd.ac = 1'b1;
			lobm_pkg::C_FIN: cmd.fin = 1'b1;
			lobm_pkg::C_RRD: cmd.rest_rd = 1'b1;
			lobm_pkg::C_RWR: cmd.rest_wr = 1'b1;
			lobm_pkg::C_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::C_EV |-> $past(state_q) == lobm_pkg::C_RD)
		else $error("level evaluated without a read");
	a_ac_after_ev: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::C_AC |-> $past(state_q) == lobm_pkg::C_EV)
		else $error("profit step out of order");
	a_rwr_after_rrd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::C_RWR |-> $past(state_q) == lobm_pkg::C_RRD)
		else $error("rest write without a read");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("several commands at once");

endmodule

@@ rtl/lobm_dp.sv @@
// Datapath: level memories, walk cursor, fill arithmetic, profit and result register.
module lobm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lobm_pkg::cmd_t               cmd,
	output lobm_pkg::sts_t               sts,
	input  logic                         in_sell,
	input  logic [lobm_pkg::QTY_W-1:0]   in_qty,
	input  logic [lobm_pkg::TICK_W-1:0]  in_tick,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lobm_pkg::QTY_W-1:0]   out_filled,
	output logic [lobm_pkg::PROFIT_W-1:0] out_profit
);

	localparam int LW = lobm_pkg::LVL_W;
	localparam int CW = lobm_pkg::CUR_W;
	localparam int QW = lobm_pkg::QTY_W;
	localparam int VW = lobm_pkg::LEVEL_W;
	localparam int PW = lobm_pkg::PROFIT_W;

	logic [VW-1:0] ask_mem [lobm_pkg::PRICE_LEVELS];
	logic [VW-1:0] bid_mem [lobm_pkg::PRICE_LEVELS];
	logic [VW-1:0] ask_rd_q, bid_rd_q;

	logic          sell_q;
	logic [QW-1:0] want_q, filled_q, got_q;
	logic [LW-1:0] lim_q, gap_q;
	logic [CW-1:0] cur_q, ask_lo_q, bid_hi_q;
	logic [PW-1:0] profit_q;
	logic [LW-1:0] clr_q;

	logic [LW-1:0] lim_in, idx, rd_addr;
	logic [CW-1:0] lim_ext;
	logic [VW-1:0] lvl, got_ext, new_lvl;
	logic [QW-1:0] got;
	logic [VW:0]   rest_sum;
	logic [VW-1:0] rest_val;
	logic [2*QW-1:0] prod;
	logic [PW:0]   psum;
	logic          rd_ask, rd_bid;
	logic          ask_we, bid_we;
	logic [LW-1:0] ask_wa, bid_wa;
	logic [VW-1:0] ask_wd, bid_wd;

	// Clamp the incoming limit to the book
	assign lim_in = (int'(in_tick) >= lobm_pkg::PRICE_LEVELS) ?
		LW'(lobm_pkg::PRICE_LEVELS - 1) : LW'(in_tick);
	assign lim_ext = {1'b0, lim_q};

	// Cursor to level index: buy walks up from cur, sell keeps cur one above
	assign idx = sell_q ? LW'(cur_q - CW'(1)) : cur_q[LW-1:0];
	assign rd_addr = cmd.rest_rd ? lim_q : idx;
	assign rd_ask = cmd.rd ? !sell_q : sell_q;
	assign rd_bid = !rd_ask;

	assign lvl = sell_q ? bid_rd_q : ask_rd_q;
	assign got = (lvl < VW'(want_q)) ? QW'(lvl) : want_q;
	assign got_ext = VW'(got);
	assign new_lvl = lvl - got_ext;

	// Resting level on the order's own side
	assign rest_sum = {1'b0, sell_q ? ask_rd_q : bid_rd_q} + (VW + 1)'(want_q);
	assign rest_val = rest_sum[VW] ? lobm_pkg::LEVEL_MAX : rest_sum[VW-1:0];

	assign prod = (2 * QW)'(got_q) * (2 * QW)'(gap_q);
	assign psum = {1'b0, profit_q} + (PW + 1)'(prod);

	assign sts.clr_done = clr_q == LW'(lobm_pkg::PRICE_LEVELS - 1);
	assign sts.walk_more = (want_q != '0) &&
		(sell_q ? (cur_q > lim_ext) : (cur_q <= lim_ext));
	assign sts.rest_needed = want_q != '0;
	assign sts.out_free = !out_valid || out_ready;

	// Select one write per memory: clearing pass, fill or rest
	assign ask_we = cmd.clr || (cmd.ev && !sell_q) || (cmd.rest_wr && sell_q);
	assign bid_we = cmd.clr || (cmd.ev && sell_q) || (cmd.rest_wr && !sell_q);
	assign ask_wa = cmd.clr ? clr_q : (cmd.ev ? idx : lim_q);
	assign bid_wa = cmd.clr ? clr_q : (cmd.ev ? idx : lim_q);
	assign ask_wd = cmd.clr ? '0 : (cmd.ev ? new_lvl : rest_val);
	assign bid_wd = cmd.clr ? '0 : (cmd.ev ? new_lvl : rest_val);

	// Level memories: one read and one write port each
	always_ff @(posedge clk) begin
		if (rd_ask && (cmd.rd || cmd.rest_rd)) ask_rd_q <= ask_mem[rd_addr];
		if (rd_bid && (cmd.rd || cmd.rest_rd)) bid_rd_q <= bid_mem[rd_addr];
		if (ask_we) ask_mem[ask_wa] <= ask_wd;
		if (bid_we) bid_mem[bid_wa] <= bid_wd;
	end

	// Order registers and fill arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sell_q <= in_sell;
			want_q <= in_qty;
			lim_q <= lim_in;
			filled_q <= '0;
			cur_q <= in_sell ? bid_hi_q : ask_lo_q;
		end
		if (cmd.ev) begin
			want_q <= want_q - got;
			filled_q <= filled_q + got;
			got_q <= got;
			gap_q <= sell_q ? (idx - lim_q) : (lim_q - idx);
			if (new_lvl == '0) cur_q <= sell_q ? cur_q - CW'(1) : cur_q + CW'(1);
		end
	end

	// Book bounds, clearing address and profit, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ask_lo_q <= CW'(lobm_pkg::PRICE_LEVELS);
			bid_hi_q <= '0;
			profit_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + LW'(1);
			if (cmd.ac) profit_q <= psum[PW] ? lobm_pkg::PROFIT_MAX : psum[PW-1:0];
			if (cmd.fin) begin
				if (sell_q) bid_hi_q <= cur_q;
				else ask_lo_q <= cur_q;
			end
			if (cmd.rest_wr) begin
				if (sell_q && (lim_ext < ask_lo_q)) ask_lo_q <= lim_ext;
				if (!sell_q && (lim_ext + CW'(1) > bid_hi_q)) bid_hi_q <= lim_ext + CW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_filled <= filled_q;
			out_profit <= profit_q;
		end
	end

endmodule

@@ rtl/limit_order_book_matcher.sv @@
// Top level of the limit order book matcher: controller and datapath joined.
// Usage: one order per slave transaction (s_tuser = side, 0 buy, 1 sell;
// s_tdata = quantity and limit tick). Every order yields exactly one master
// transaction carrying the units filled and the running profit total.
// A buy walks resting ask levels upward from the lowest possibly occupied
// one; a sell walks bid levels downward from the highest. Each level visited
// passes through check, memory read, fill and profit accumulate steps, the
// level memories having one read port per side. Empty levels between the
// tracked book edge and the limit are visited too.
// After the walk come a finish step and, when a remainder rests, a rest read
// and write before the result is loaded; the next order is taken once the
// controller is back in idle.
// One order is processed at a time; s_tready is high only while idle.
// The result sits in an output register, so a stalled m_tready blocks
// the next order only once that order's own result is ready to leave.
// Reset clears the book edges and the profit total at once, then a clearing
// pass zeroes every address of both level memories with s_tready held low.
// Profit and resting levels saturate rather than wrap.
module limit_order_book_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] quantity, [25:16] limit_tick, [31:26] zero
	input  logic        s_tuser,  // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // [15:0] filled_qty, [63:16] total_profit
);

	lobm_pkg::cmd_t cmd;
	lobm_pkg::sts_t sts;
	logic [lobm_pkg::QTY_W-1:0]    filled;
	logic [lobm_pkg::PROFIT_W-1:0] profit;

	lobm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lobm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_sell    (s_tuser),
		.in_qty     (s_tdata[15:0]),
		.in_tick    (s_tdata[25:16]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_filled (filled),
		.out_profit (profit)
	);

	assign m_tdata = {profit, filled};

endmodule
